### src/pwlc_pkg.sv
// ----------------------------------------------------------------------------
// pwlc_pkg
// Shared types and constants of the pairing window / status LED controller.
// ----------------------------------------------------------------------------
package pwlc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned GEST_W   = 2;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned PHASE_W  = 7;

  localparam logic [CFG_W-1:0] RESET_PAIR_WIN_LEN = CFG_W'(10000);
  localparam logic [CFG_W-1:0] RESET_FLASH_LEN    = CFG_W'(1200);

  // Idle flash: on for IDLE_ON_TICKS out of every IDLE_PERIOD ticks.
  localparam logic [PHASE_W-1:0] IDLE_PERIOD   = PHASE_W'(66);
  localparam logic [PHASE_W-1:0] IDLE_ON_TICKS = PHASE_W'(3);

  // Blink rates: tick_count / 16 and tick_count / 4, taken mod 2.
  localparam int unsigned CONFIG_BLINK_BIT  = 4;
  localparam int unsigned PAIRING_BLINK_BIT = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAIR_WIN_LEN = 1'd0,
    REG_FLASH_LEN    = 1'd1
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_READY      = 2'd1,
    CMD_DISCONNECT = 2'd2
  } cmd_t;

  typedef enum logic [GEST_W-1:0] {
    GEST_NONE   = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_TRIPLE = 2'd2,
    GEST_HOLD   = 2'd3
  } gesture_t;

  // Inputs of the LED priority select.
  typedef struct packed {
    logic config_mode;
    logic wipe_active;
    logic pairing_open;
    logic connected;
    logic config_blink;
    logic pairing_blink;
    logic fast_blink;
    logic idle_on;
  } led_sel_t;

endpackage

### src/pwlc_if.sv
// ----------------------------------------------------------------------------
// pwlc_if
// Valid/ready channels: input items and result items.
// ----------------------------------------------------------------------------
interface pwlc_in_if;
  logic                                valid;
  logic                                ready;
  logic [pwlc_pkg::CMD_W-1:0]          cmd;
  logic [pwlc_pkg::TIME_W-1:0]         now_ms;
  logic [pwlc_pkg::GEST_W-1:0]         gesture;
  logic                                config_mode;

  modport source (output valid, cmd, now_ms, gesture, config_mode, input ready);
  modport sink   (input valid, cmd, now_ms, gesture, config_mode, output ready);
endinterface

interface pwlc_out_if;
  logic valid;
  logic ready;
  logic led;
  logic allowlist_enforced;
  logic pairing_open;
  logic wipe_request;
  logic config_request;

  modport source (output valid, led, allowlist_enforced, pairing_open, wipe_request,
                  config_request, input ready);
  modport sink   (input valid, led, allowlist_enforced, pairing_open, wipe_request,
                  config_request, output ready);
endinterface

### src/pwlc_led_sel.sv
// ----------------------------------------------------------------------------
// pwlc_led_sel
// Status LED priority: config blink, wipe flash, pairing blink, solid, idle.
// ----------------------------------------------------------------------------
module pwlc_led_sel (
  input  pwlc_pkg::led_sel_t sel,
  output logic               led
);

  always_comb begin
    priority if (sel.config_mode) begin
      led = sel.config_blink;
    end else if (sel.wipe_active) begin
      led = sel.fast_blink;
    end else if (sel.pairing_open) begin
      led = sel.pairing_blink;
    end else if (sel.connected) begin
      led = 1'b1;
    end else begin
      led = sel.idle_on;
    end
  end

endmodule

### src/pairing_window_led_controller.sv
// ----------------------------------------------------------------------------
// pairing_window_led_controller
// Pairing window, allow-list and status LED control for a wireless dongle.
//
// Channels: in_ch carries one beat per event (tick, controller ready,
// controller disconnected); out_ch carries one result beat per tick only.
// Ready and disconnect beats update the connected count and give no result;
// an unused command code is consumed silently.
// Configuration: cfg_we/cfg_index/cfg_data write the pairing window and
// wipe flash lengths (ms); write only while no beat is in flight.
// Path: a tick accepted into the input register moves on into the result
// register once out_ch is free, and its result is then held valid there.
// Throughput: one beat per cycle unless out_ch stalls, set by the input
// register feeding one add-and-compare stage writing state and result.
// Stall: while out_ch is stalled the result holds; one more tick may sit
// in the input register, after which in_ch.ready drops. Events still
// drain past a stalled result.
// Reset (rst, synchronous): both channels empty, window closed, no wipe
// flash, counts zero, allow-list enforced, lengths 10000 ms and 1200 ms.
// ----------------------------------------------------------------------------
module pairing_window_led_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pwlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwlc_pkg::CFG_W-1:0]         cfg_data,
  pwlc_in_if.sink                            in_ch,
  pwlc_out_if.source                         out_ch
);

  logic [pwlc_pkg::CFG_W-1:0]   pair_win_len;
  logic [pwlc_pkg::CFG_W-1:0]   flash_len;

  // input register
  logic                         s1_valid;
  logic [pwlc_pkg::CMD_W-1:0]   s1_cmd;
  logic [pwlc_pkg::TIME_W-1:0]  s1_now;
  logic [pwlc_pkg::GEST_W-1:0]  s1_gesture;
  logic                         s1_config_mode;

  // state
  logic [pwlc_pkg::TIME_W-1:0]  pairing_deadline;
  logic [pwlc_pkg::TIME_W-1:0]  wipe_deadline;
  logic [pwlc_pkg::TIME_W-1:0]  tick_count;
  logic [pwlc_pkg::PHASE_W-1:0] idle_phase;
  logic [pwlc_pkg::COUNT_W-1:0] connected_count;
  logic                         enforce_flag;

  // result register
  logic                         o_valid;
  logic                         o_led;
  logic                         o_enforced;
  logic                         o_pairing_open;
  logic                         o_wipe_req;
  logic                         o_cfg_req;

  logic                         out_free;
  logic                         s1_is_tick;
  logic                         s1_fire;
  logic                         tick_fire;
  logic [pwlc_pkg::GEST_W-1:0]  gest_eff;
  logic [pwlc_pkg::TIME_W-1:0]  pairing_deadline_next;
  logic [pwlc_pkg::TIME_W-1:0]  wipe_deadline_next;
  logic [pwlc_pkg::TIME_W-1:0]  pd_gest;
  logic                         en_gest;
  logic                         expire;
  logic                         enforce_next;
  logic                         wipe_req_next;
  logic                         cfg_req_next;
  logic [pwlc_pkg::COUNT_W-1:0] connected_count_next;
  logic [pwlc_pkg::PHASE_W-1:0] idle_phase_next;
  pwlc_pkg::led_sel_t           led_sel;
  logic                         led_next;

  assign out_free   = !o_valid || out_ch.ready;
  assign s1_is_tick = (s1_cmd == pwlc_pkg::CMD_TICK);
  assign s1_fire    = s1_valid && (!s1_is_tick || out_free);
  assign tick_fire  = s1_fire && s1_is_tick;
  assign in_ch.ready = !s1_valid || s1_fire;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_win_len <= pwlc_pkg::RESET_PAIR_WIN_LEN;
      flash_len    <= pwlc_pkg::RESET_FLASH_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwlc_pkg::REG_PAIR_WIN_LEN: pair_win_len <= cfg_data;
        pwlc_pkg::REG_FLASH_LEN:    flash_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd         <= in_ch.cmd;
      s1_now         <= in_ch.now_ms;
      s1_gesture     <= in_ch.gesture;
      s1_config_mode <= in_ch.config_mode;
    end
  end

  // tick logic
  always_comb begin
    gest_eff       = s1_config_mode ? pwlc_pkg::GEST_NONE : s1_gesture;
    pd_gest        = pairing_deadline;
    en_gest        = enforce_flag;
    wipe_deadline_next = wipe_deadline;
    wipe_req_next  = 1'b0;
    cfg_req_next   = 1'b0;
    unique case (gest_eff)
      pwlc_pkg::GEST_DOUBLE: begin
        pd_gest = s1_now + pwlc_pkg::TIME_W'(pair_win_len);
        en_gest = 1'b0;
      end
      pwlc_pkg::GEST_TRIPLE: begin
        pd_gest            = '0;
        en_gest            = 1'b1;
        wipe_deadline_next = s1_now + pwlc_pkg::TIME_W'(flash_len);
        wipe_req_next      = 1'b1;
      end
      pwlc_pkg::GEST_HOLD: begin
        cfg_req_next = 1'b1;
      end
      default: ;
    endcase
    expire                = (pd_gest != '0) && (s1_now >= pd_gest);
    pairing_deadline_next = expire ? '0 : pd_gest;
    enforce_next          = expire ? 1'b1 : en_gest;
  end

  always_comb begin
    led_sel.config_mode   = s1_config_mode;
    led_sel.wipe_active   = (wipe_deadline_next != '0) && (s1_now < wipe_deadline_next);
    led_sel.pairing_open  = (pairing_deadline_next != '0);
    led_sel.connected     = (connected_count != '0);
    led_sel.config_blink  = !tick_count[pwlc_pkg::CONFIG_BLINK_BIT];
    led_sel.pairing_blink = !tick_count[pwlc_pkg::PAIRING_BLINK_BIT];
    led_sel.fast_blink    = tick_count[0];
    led_sel.idle_on       = (idle_phase < pwlc_pkg::IDLE_ON_TICKS);
  end

  pwlc_led_sel u_led_sel (
    .sel (led_sel),
    .led (led_next)
  );

  // idle phase tracks tick_count mod 66, including the 2^32 wrap
  always_comb begin
    if (tick_count == '1) begin
      idle_phase_next = '0;
    end else if (idle_phase == pwlc_pkg::IDLE_PERIOD - pwlc_pkg::PHASE_W'(1)) begin
      idle_phase_next = '0;
    end else begin
      idle_phase_next = idle_phase + pwlc_pkg::PHASE_W'(1);
    end
  end

  always_comb begin
    connected_count_next = connected_count;
    unique case (s1_cmd)
      pwlc_pkg::CMD_READY: begin
        if (connected_count != pwlc_pkg::COUNT_MAX) begin
          connected_count_next = connected_count + pwlc_pkg::COUNT_W'(1);
        end
      end
      pwlc_pkg::CMD_DISCONNECT: begin
        if (connected_count != '0) begin
          connected_count_next = connected_count - pwlc_pkg::COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // state
  always_ff @(posedge clk) begin
    if (rst) begin
      pairing_deadline <= '0;
      wipe_deadline    <= '0;
      tick_count       <= '0;
      idle_phase       <= '0;
      connected_count  <= '0;
      enforce_flag     <= 1'b1;
    end else if (s1_fire) begin
      connected_count <= connected_count_next;
      if (s1_is_tick) begin
        pairing_deadline <= pairing_deadline_next;
        wipe_deadline    <= wipe_deadline_next;
        enforce_flag     <= enforce_next;
        tick_count       <= tick_count + pwlc_pkg::TIME_W'(1);
        idle_phase       <= idle_phase_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (tick_fire) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      o_led          <= led_next;
      o_enforced     <= enforce_next;
      o_pairing_open <= (pairing_deadline_next != '0);
      o_wipe_req     <= wipe_req_next;
      o_cfg_req      <= cfg_req_next;
    end
  end

  assign out_ch.valid              = o_valid;
  assign out_ch.led                = o_led;
  assign out_ch.allowlist_enforced = o_enforced;
  assign out_ch.pairing_open       = o_pairing_open;
  assign out_ch.wipe_request       = o_wipe_req;
  assign out_ch.config_request     = o_cfg_req;

endmodule

### src/pwlc_chk.sv
// ----------------------------------------------------------------------------
// pwlc_chk
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module pwlc_chk (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic led,
  input logic allowlist_enforced,
  input logic pairing_open,
  input logic wipe_request,
  input logic config_request
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({led, allowlist_enforced, pairing_open, wipe_request, config_request}))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(wipe_request && config_request))
    else $error("wipe and config request together");

  a_wipe_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && wipe_request |-> allowlist_enforced && !pairing_open)
    else $error("wipe left window open or allow-list lifted");

  a_open_lifts: assert property (@(posedge clk) disable iff (rst)
    out_valid && pairing_open |-> !allowlist_enforced)
    else $error("pairing window open while allow-list enforced");

endmodule

bind pairing_window_led_controller pwlc_chk u_pwlc_chk (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .led                (out_ch.led),
  .allowlist_enforced (out_ch.allowlist_enforced),
  .pairing_open       (out_ch.pairing_open),
  .wipe_request       (out_ch.wipe_request),
  .config_request     (out_ch.config_request)
);
